/* rtl/krt_pkg.sv */
// shared types and constants for the keyed record table
// no dependencies
package krt_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 64;
  localparam int PHONE_W = 64;
  localparam int ADDR_W  = 64;
  localparam int AGE_W   = 8;
  localparam int STAT_W  = 2;
  localparam int HIT_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_SEARCH   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_SET_PHONE = 3'd3,
    CMD_SET_ADDR = 3'd4,
    CMD_SET_AGE  = 3'd5
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_WRITE,
    ST_SHIFT,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PHONE_W-1:0] phone;
    logic [ADDR_W-1:0]  address;
    logic [AGE_W-1:0]   age;
  } rec_t;

  // commands from controller to datapath
  typedef struct packed {
    logic   load;
    logic   add;
    logic   scan;
    logic   write_hit;
    logic   shift;
    cmd_e_t cmd;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic match;
    logic scan_miss;
    logic shift_done;
  } dp_stat_t;

endpackage

/* rtl/krt_ctrl.sv */
// controller state machine for the keyed record table
// depends on krt_pkg
module krt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [krt_pkg::CMD_W-1:0]  command,
  input  krt_pkg::dp_stat_t          stat,
  output krt_pkg::ctl_t              ctl,
  output logic                       busy,
  output logic                       done
);
  import krt_pkg::*;

  state_t state, state_next;
  cmd_e_t cmd_r, cmd_r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_r_next;
  end

  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    ctl           = '0;
    ctl.cmd       = cmd_r;
    done          = 1'b0;
    busy          = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          cmd_r_next = cmd_e_t'(command);
          unique case (command) inside
            CMD_ADD: state_next = ST_ADD;
            CMD_SEARCH, CMD_DELETE, CMD_SET_PHONE, CMD_SET_ADDR, CMD_SET_AGE:
              state_next = ST_SCAN;
            default: state_next = ST_REPLY;
          endcase
        end
      end
      ST_ADD: begin
        ctl.add    = 1'b1;
        state_next = ST_REPLY;
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.match) begin
          if (cmd_r == CMD_DELETE) begin
            state_next = ST_SHIFT;
          end else if (cmd_r == CMD_SEARCH) begin
            state_next = ST_REPLY;
          end else begin
            state_next = ST_WRITE;
          end
        end else if (stat.scan_miss) begin
          state_next = ST_REPLY;
        end
      end
      ST_WRITE: begin
        ctl.write_hit = 1'b1;
        state_next    = ST_REPLY;
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/krt_datapath.sv */
// record memory, scan and shift pointers and result registers
// depends on krt_pkg; driven by krt_ctrl
module krt_datapath #(
  parameter int TABLE_ENTRIES = krt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  krt_pkg::ctl_t                ctl,
  input  logic [krt_pkg::KEY_W-1:0]    key_name,
  input  logic [krt_pkg::PHONE_W-1:0]  phone_value,
  input  logic [krt_pkg::ADDR_W-1:0]   address_value,
  input  logic [krt_pkg::AGE_W-1:0]    age_value,
  output krt_pkg::dp_stat_t            stat,
  output logic [krt_pkg::STAT_W-1:0]   status,
  output logic [krt_pkg::HIT_W-1:0]    hit_index,
  output logic [krt_pkg::PHONE_W-1:0]  found_phone,
  output logic [krt_pkg::ADDR_W-1:0]   found_address,
  output logic [krt_pkg::AGE_W-1:0]    found_age,
  output logic [krt_pkg::COUNT_W-1:0]  entry_count
);
  import krt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  rec_t mem [TABLE_ENTRIES];
  rec_t rdata;
  rec_t in_r;
  rec_t rec_r;
  rec_t wdata;
  rec_t hit_rec;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] hit_idx;
  status_e_t        status_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic             more;
  logic             full;
  logic             match;

  assign more  = (ptr < count);
  assign full  = (count == FULL_COUNT);
  assign raddr = ptr[IDX_W-1:0];
  assign match = pend && (rdata.key == in_r.key);

  assign stat.match      = ctl.scan && match;
  assign stat.scan_miss  = !pend && !more;
  assign stat.shift_done = !pend && !more;

  // matched row with the update command applied
  always_comb begin
    hit_rec = rdata;
    case (ctl.cmd)
      CMD_SET_PHONE: hit_rec.phone   = in_r.phone;
      CMD_SET_ADDR:  hit_rec.address = in_r.address;
      CMD_SET_AGE:   hit_rec.age     = in_r.age;
      default:       hit_rec = rdata;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = hit_idx;
    wdata = rec_r;
    if (ctl.add && !full) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = in_r;
    end else if (ctl.write_hit) begin
      we = 1'b1;
    end else if (ctl.shift && pend) begin
      // row read last cycle moves down one place
      we    = 1'b1;
      waddr = pend_idx - IDX_W'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      pend  <= 1'b0;
    end else if (ctl.load) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (ctl.add) begin
      if (!full) begin
        count <= count + CNT_W'(1);
      end
    end else if (ctl.scan || ctl.shift) begin
      if (ctl.scan && match) begin
        ptr  <= CNT_W'(pend_idx) + CNT_W'(1);
        pend <= 1'b0;
      end else if (more) begin
        ptr  <= ptr + CNT_W'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
        if (ctl.shift && !pend) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_r     <= '{key: key_name, phone: phone_value, address: address_value,
                    age: age_value};
      rec_r    <= '0;
      hit_idx  <= '0;
      status_r <= STAT_MISSING;
    end else if (ctl.add) begin
      if (full) begin
        status_r <= STAT_FULL;
      end else begin
        status_r <= STAT_OK;
        rec_r    <= in_r;
        hit_idx  <= count[IDX_W-1:0];
      end
    end else if (ctl.scan && match) begin
      status_r <= STAT_OK;
      rec_r    <= hit_rec;
      hit_idx  <= pend_idx;
    end
    if (ctl.scan || ctl.shift) begin
      if (more && !(ctl.scan && match)) begin
        pend_idx <= raddr;
      end
    end
  end

  assign status        = status_r;
  assign hit_index     = HIT_W'(hit_idx);
  assign found_phone   = rec_r.phone;
  assign found_address = rec_r.address;
  assign found_age     = rec_r.age;
  assign entry_count   = COUNT_W'(count);

endmodule

/* rtl/keyed_record_table.sv */
// top level of the keyed record table: controller plus datapath
// depends on krt_pkg, krt_ctrl, krt_datapath
//
//  channel   handshake          fields
//  command   start / busy       command, key_name, phone_value, address_value, age_value
//  result    done (one cycle)   status, hit_index, found_phone, found_address,
//                               found_age, entry_count
//
// add goes through ST_ADD to ST_REPLY and unknown codes straight to ST_REPLY, which raises done
// search and update on n entries scan them from row 0 up, one entry read a cycle;
// a hit ends the scan and an update then writes the changed row back in ST_WRITE
// delete of row p moves the n - 1 - p later entries down one a cycle
// reset empties the table at once; busy falls the cycle after done
// results cannot be held off: done marks them for exactly one cycle
module keyed_record_table #(
  parameter int TABLE_ENTRIES = krt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [krt_pkg::CMD_W-1:0]    command,
  input  logic [krt_pkg::KEY_W-1:0]    key_name,
  input  logic [krt_pkg::PHONE_W-1:0]  phone_value,
  input  logic [krt_pkg::ADDR_W-1:0]   address_value,
  input  logic [krt_pkg::AGE_W-1:0]    age_value,
  output logic                         done,
  output logic [krt_pkg::STAT_W-1:0]   status,
  output logic [krt_pkg::HIT_W-1:0]    hit_index,
  output logic [krt_pkg::PHONE_W-1:0]  found_phone,
  output logic [krt_pkg::ADDR_W-1:0]   found_address,
  output logic [krt_pkg::AGE_W-1:0]    found_age,
  output logic [krt_pkg::COUNT_W-1:0]  entry_count
);
  import krt_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  krt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  krt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .key_name      (key_name),
    .phone_value   (phone_value),
    .address_value (address_value),
    .age_value     (age_value),
    .stat          (stat),
    .status        (status),
    .hit_index     (hit_index),
    .found_phone   (found_phone),
    .found_address (found_address),
    .found_age     (found_age),
    .entry_count   (entry_count)
  );

endmodule

/* rtl/krt_checker.sv */
// port-level checks for the keyed record table, bound to the top level
// depends on krt_pkg and keyed_record_table
module krt_checker #(
  parameter int TABLE_ENTRIES = krt_pkg::DEF_TABLE_ENTRIES
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [krt_pkg::STAT_W-1:0]   status,
  input logic [krt_pkg::HIT_W-1:0]    hit_index,
  input logic [krt_pkg::PHONE_W-1:0]  found_phone,
  input logic [krt_pkg::ADDR_W-1:0]   found_address,
  input logic [krt_pkg::AGE_W-1:0]    found_age,
  input logic [krt_pkg::COUNT_W-1:0]  entry_count
);
  import krt_pkg::*;

  // a transfer always leads to a busy period
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("no busy after command transfer");

  // a result comes while busy and busy drops right after
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 (!busy && !done))
    else $error("result not closing the command");

  // failed commands report no row
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_OK |->
      hit_index == '0 && found_phone == '0 && found_address == '0 && found_age == '0)
    else $error("row fields set on failed command");

  // full only when the table holds every entry
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_FULL |-> entry_count == COUNT_W'(TABLE_ENTRIES))
    else $error("full reported with room left");

endmodule

bind keyed_record_table krt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_krt_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for keyed_record_table: directed and random table commands,
// each reply checked against an in-bench copy of the record table
// depends on krt_pkg and the keyed_record_table rtl
module tb;
  import krt_pkg::*;

  localparam int DEPTH         = DEF_TABLE_ENTRIES;
  localparam int RANDOM_ITEMS  = 1780;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
  localparam int REPORT_LIMIT  = 10;
  localparam int KEY_POOL      = 6;

  // codes with no command behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [HIT_W-1:0]   hit;
    logic [PHONE_W-1:0] phone;
    logic [ADDR_W-1:0]  address;
    logic [AGE_W-1:0]   age;
    logic [COUNT_W-1:0] count;
  } reply_t;

  class record_table_scoreboard;
    logic [KEY_W-1:0]   keys[DEPTH];
    logic [PHONE_W-1:0] phones[DEPTH];
    logic [ADDR_W-1:0]  addresses[DEPTH];
    logic [AGE_W-1:0]   ages[DEPTH];
    int unsigned        held;
    reply_t             awaited_replies[$];
    int unsigned        mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int find_first(logic [KEY_W-1:0] key);
      for (int k = 0; k < held; k++) begin
        if (keys[k] == key) return k;
      end
      return -1;
    endfunction

    function reply_t apply_record_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [PHONE_W-1:0] phone,
                                          logic [ADDR_W-1:0] address,
                                          logic [AGE_W-1:0] age);
      reply_t r;
      int row;
      r.status  = STAT_MISSING;
      r.hit     = '0;
      r.phone   = '0;
      r.address = '0;
      r.age     = '0;
      row = -1;
      if (cmd == CMD_ADD) begin
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          keys[held]      = key;
          phones[held]    = phone;
          addresses[held] = address;
          ages[held]      = age;
          row = held;
          held++;
        end
      end else if (cmd <= CMD_SET_AGE) begin
        row = find_first(key);
        if (row >= 0) begin
          case (cmd)
            CMD_SET_PHONE: phones[row] = phone;
            CMD_SET_ADDR:  addresses[row] = address;
            CMD_SET_AGE:   ages[row] = age;
            default: ;
          endcase
        end
      end
      if (row >= 0) begin
        // a removed entry is reported as it stood before the shift
        r.status  = STAT_OK;
        r.hit     = HIT_W'(row);
        r.phone   = phones[row];
        r.address = addresses[row];
        r.age     = ages[row];
        if (cmd == CMD_DELETE) begin
          for (int k = row; k + 1 < held; k++) begin
            keys[k]      = keys[k + 1];
            phones[k]    = phones[k + 1];
            addresses[k] = addresses[k + 1];
            ages[k]      = ages[k + 1];
          end
          held--;
        end
      end
      r.count = COUNT_W'(held);
      return r;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [PHONE_W-1:0] phone, logic [ADDR_W-1:0] address,
                               logic [AGE_W-1:0] age);
      awaited_replies.push_back(apply_record_command(cmd, key, phone, address, age));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: st %0d hit %0d ph %h ad %h age %0d cnt %0d",
                   got.status, got.hit, got.phone, got.address, got.age, got.count);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status || got.hit !== want.hit || got.phone !== want.phone ||
          got.address !== want.address || got.age !== want.age || got.count !== want.count)
      begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("reply mismatch: expected st %0d hit %0d ph %h ad %h age %0d cnt %0d",
                   want.status, want.hit, want.phone, want.address, want.age, want.count);
          $display("                actual   st %0d hit %0d ph %h ad %h age %0d cnt %0d",
                   got.status, got.hit, got.phone, got.address, got.age, got.count);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key_name;
  logic [PHONE_W-1:0] phone_value;
  logic [ADDR_W-1:0]  address_value;
  logic [AGE_W-1:0]   age_value;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic [HIT_W-1:0]   hit_index;
  logic [PHONE_W-1:0] found_phone;
  logic [ADDR_W-1:0]  found_address;
  logic [AGE_W-1:0]   found_age;
  logic [COUNT_W-1:0] entry_count;

  record_table_scoreboard sb;
  reply_t                 seen_reply;
  logic [KEY_W-1:0]       key_pool[KEY_POOL];
  int                     sender_idle_pct;
  bit                     filling;
  int                     items_at_full;
  int unsigned            cycle_count = 0;

  keyed_record_table #(.TABLE_ENTRIES(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .key_name      (key_name),
    .phone_value   (phone_value),
    .address_value (address_value),
    .age_value     (age_value),
    .done          (done),
    .status        (status),
    .hit_index     (hit_index),
    .found_phone   (found_phone),
    .found_address (found_address),
    .found_age     (found_age),
    .entry_count   (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // results cannot be held off, so every done cycle is a transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_reply.status  = status;
      seen_reply.hit     = hit_index;
      seen_reply.phone   = found_phone;
      seen_reply.address = found_address;
      seen_reply.age     = found_age;
      seen_reply.count   = entry_count;
      sb.check_reply(seen_reply);
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // keys already in the table with chance hit_pct, so that searches and updates hit
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    if (sb.held != 0 && $urandom_range(99) < hit_pct)
      return sb.keys[$urandom_range(sb.held - 1)];
    if ($urandom_range(1) != 0)
      return key_pool[$urandom_range(KEY_POOL - 1)];
    return rand_word();
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [PHONE_W-1:0] phone,
                              input logic [ADDR_W-1:0] address,
                              input logic [AGE_W-1:0] age);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start         = 1'b1;
    command       = cmd;
    key_name      = key;
    phone_value   = phone;
    address_value = address;
    age_value     = age;
    // transfer happens on the first edge that sees busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, key, phone, address, age);
    @(negedge clk);
  endtask

  // fill the table until adds bounce off the full table, then drain it again
  task automatic issue_random_command();
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(99);
    if (filling) begin
      cmd = (roll < 60) ? CMD_ADD : CMD_W'($urandom_range(CMD_UNUSED_HI));
    end else begin
      if (roll < 45)      cmd = CMD_DELETE;
      else if (roll < 55) cmd = CMD_ADD;
      else                cmd = CMD_W'($urandom_range(CMD_UNUSED_HI));
    end
    key = (cmd == CMD_ADD) ? pick_key(20) : pick_key(75);
    send_command(cmd, key, rand_word(), rand_word(), AGE_W'($urandom_range(255)));
    if (filling && sb.held == DEPTH) begin
      items_at_full++;
      if (items_at_full > 6) filling = 1'b0;
    end else if (!filling && sb.held <= 1) begin
      filling = 1'b1;
      items_at_full = 0;
    end
  endtask

  initial begin
    int n;
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_ADD;
    key_name      = '0;
    phone_value   = '0;
    address_value = '0;
    age_value     = '0;
    sender_idle_pct = 18;
    filling         = 1'b1;
    items_at_full   = 0;
    sb = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table: everything misses
    send_command(CMD_SEARCH, '0, '0, '0, '0);
    send_command(CMD_DELETE, '1, '0, '0, '0);
    send_command(CMD_SET_PHONE, '0, '1, '0, '0);
    send_command(CMD_UNUSED_LO, '0, '0, '0, '0);
    send_command(CMD_UNUSED_HI, '1, '1, '1, '1);
    // extremes and a duplicate key
    send_command(CMD_ADD, '0, '0, '0, '0);
    send_command(CMD_ADD, '1, '1, '1, '1);
    send_command(CMD_ADD, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 8'h5a);
    send_command(CMD_SEARCH, '1, '0, '0, '0);
    send_command(CMD_SET_PHONE, '1, '0, '1, '1);
    send_command(CMD_SET_ADDR, '1, '1, 64'h5555_aaaa_5555_aaaa, '1);
    send_command(CMD_SET_AGE, '1, '1, '1, '0);
    send_command(CMD_SET_AGE, '0, '0, '0, '1);
    // delete of the first match uncovers the duplicate behind it
    send_command(CMD_DELETE, '1, '0, '0, '0);
    send_command(CMD_SEARCH, '1, '0, '0, '0);
    send_command(CMD_DELETE, '0, '0, '0, '0);
    send_command(CMD_SEARCH, '0, '0, '0, '0);
    send_command(CMD_UNUSED_LO, '1, '0, '0, '0);
    send_command(CMD_UNUSED_HI, '1, '0, '0, '0);
    send_command(CMD_DELETE, 64'h1234_0000_0000_4321, '0, '0, '0);
    send_command(CMD_SET_ADDR, 64'h8000_0000_0000_0001, '0, '1, '0);
    send_command(CMD_DELETE, '1, '0, '0, '0);
    send_command(CMD_SEARCH, '1, '0, '0, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) sender_idle_pct = 85;
      if (n == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      issue_random_command();
    end
    start = 1'b0;

    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
